[rtl/rdc_pkg.sv]
package rdc_pkg;

	// Array and value space
	localparam int ARRAY_DEPTH = 1024;
	localparam int VALUE_COUNT = 1024;

	// Fixed field widths of the item and result beats
	localparam int POS_W      = 11;
	localparam int VALUE_IN_W = 10;
	localparam int CNT_W      = 11;
	localparam int STAMP_W    = 16;

	// Derived storage widths
	localparam int ADDR_W  = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
	localparam int VAL_W   = $clog2(VALUE_COUNT);
	localparam int SWEEP_N = (ARRAY_DEPTH > VALUE_COUNT) ? ARRAY_DEPTH : VALUE_COUNT;
	localparam int SWEEP_W = (SWEEP_N > 1) ? $clog2(SWEEP_N) : 1;

	// Item kinds carried on the input tuser
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WIPE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} rdc_state_t;

	// Commands from the sequencer to the memory datapath
	typedef struct packed {
		logic               val_we;
		logic [ADDR_W-1:0]  val_waddr;
		logic [VAL_W-1:0]   val_wdata;
		logic               clear_seen;
		logic [SWEEP_W-1:0] clear_addr;
		logic               rd_issue;
		logic [ADDR_W-1:0]  rd_addr;
		logic               start;
		logic [STAMP_W-1:0] stamp;
	} rdc_ctl_t;

endpackage

[rtl/rdc_ram.sv]
module rdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/rdc_scan.sv]
module rdc_scan import rdc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  rdc_ctl_t         ctl,
	output logic             busy,
	output logic [CNT_W-1:0] count
);

	logic [VAL_W-1:0]   val_rd;
	logic [STAMP_W-1:0] seen_rd;
	logic               valid_s1;
	logic               valid_s2;
	logic [VAL_W-1:0]   v_s2;
	logic               valid_s3;
	logic [VAL_W-1:0]   v_s3;
	logic               hit;
	logic               fresh;
	logic               seen_we;
	logic [VAL_W-1:0]   seen_waddr;
	logic [STAMP_W-1:0] seen_wdata;
	logic [CNT_W-1:0]   count_q;

	rdc_ram #(
		.WIDTH (VAL_W),
		.DEPTH (ARRAY_DEPTH),
		.AW    (ADDR_W)
	) u_value_ram (
		.clk   (clk),
		.we    (ctl.val_we),
		.waddr (ctl.val_waddr),
		.wdata (ctl.val_wdata),
		.raddr (ctl.rd_addr),
		.rdata (val_rd)
	);

	// The seen store is read with the value that has just come out of the value store.
	rdc_ram #(
		.WIDTH (STAMP_W),
		.DEPTH (VALUE_COUNT),
		.AW    (VAL_W)
	) u_seen_ram (
		.clk   (clk),
		.we    (seen_we),
		.waddr (seen_waddr),
		.wdata (seen_wdata),
		.raddr (val_rd),
		.rdata (seen_rd)
	);

	// The previous position's stamp write lands in the cycle this position's read
	// happens, so an equal value one step back is forwarded as already seen.
	assign hit   = (seen_rd == ctl.stamp) || (valid_s3 && (v_s3 == v_s2));
	assign fresh = valid_s2 && !hit;

	assign seen_we    = ctl.clear_seen || fresh;
	assign seen_waddr = ctl.clear_seen ? VAL_W'(ctl.clear_addr) : v_s2;
	assign seen_wdata = ctl.clear_seen ? '0 : ctl.stamp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			count_q  <= '0;
		end else begin
			valid_s1 <= ctl.rd_issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (ctl.start) begin
				count_q <= '0;
			end else if (fresh) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		v_s2 <= val_rd;
		v_s3 <= v_s2;
	end

	assign busy  = valid_s1 || valid_s2;
	assign count = count_q;

endmodule

[rtl/rdc_ctrl.sv]
module rdc_ctrl import rdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_accept,
	input  logic                  func,
	input  logic [POS_W-1:0]      write_index,
	input  logic [VALUE_IN_W-1:0] write_value,
	input  logic [POS_W-1:0]      query_left,
	input  logic [POS_W-1:0]      query_right,
	input  logic                  busy,
	input  logic                  out_free,
	output logic                  ready,
	output logic                  load_out,
	output rdc_ctl_t              ctl
);

	rdc_state_t         state_q;
	rdc_state_t         state_d;
	logic [SWEEP_W-1:0] sweep_q;
	logic [ADDR_W-1:0]  scan_q;
	logic [ADDR_W-1:0]  hi_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [POS_W-1:0]   lo_pos;
	logic [POS_W-1:0]   hi_pos;
	logic               empty;
	logic               wrap;
	logic               query_acc;
	logic               write_ok;
	logic               sweep_last;
	logic               wipe_last;

	// Range bounds after clamping to the array
	assign lo_pos = (query_left == '0) ? POS_W'(1) : query_left;
	assign hi_pos = (32'(query_right) > 32'(ARRAY_DEPTH)) ? POS_W'(ARRAY_DEPTH) : query_right;
	assign empty  = lo_pos > hi_pos;
	assign wrap   = (stamp_q == '1);

	assign query_acc = (state_q == ST_IDLE) && in_accept && (func == FUNC_QUERY);
	assign write_ok  = (write_index != '0) && (32'(write_index) <= 32'(ARRAY_DEPTH)) &&
		(32'(write_value) < 32'(VALUE_COUNT));

	assign sweep_last = (sweep_q == SWEEP_W'(SWEEP_N - 1));
	assign wipe_last  = (sweep_q == SWEEP_W'(VALUE_COUNT - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (query_acc) begin
					if (empty) begin
						state_d = ST_FINISH;
					end else if (wrap) begin
						state_d = ST_WIPE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_WIPE: begin
				if (wipe_last) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_q == hi_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		ready          = 1'b0;
		load_out       = 1'b0;
		ctl.val_we     = 1'b0;
		ctl.val_waddr  = ADDR_W'(sweep_q);
		ctl.val_wdata  = '0;
		ctl.clear_seen = 1'b0;
		ctl.clear_addr = sweep_q;
		ctl.rd_issue   = 1'b0;
		ctl.rd_addr    = scan_q;
		ctl.start      = 1'b0;
		ctl.stamp      = stamp_q;
		case (state_q)
			ST_CLEAR: begin
				ctl.val_we     = (32'(sweep_q) < 32'(ARRAY_DEPTH));
				ctl.clear_seen = (32'(sweep_q) < 32'(VALUE_COUNT));
			end
			ST_IDLE: begin
				ready         = 1'b1;
				ctl.val_we    = in_accept && (func == FUNC_WRITE) && write_ok;
				ctl.val_waddr = ADDR_W'(write_index - POS_W'(1));
				ctl.val_wdata = VAL_W'(write_value);
				ctl.start     = query_acc;
			end
			ST_WIPE: begin
				ctl.clear_seen = 1'b1;
			end
			ST_SCAN: begin
				ctl.rd_issue = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_FINISH: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sweep_q <= '0;
			stamp_q <= '0;
			scan_q  <= '0;
			hi_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR || state_q == ST_WIPE) begin
				sweep_q <= sweep_q + SWEEP_W'(1);
			end
			if (query_acc) begin
				scan_q <= ADDR_W'(lo_pos - POS_W'(1));
				hi_q   <= ADDR_W'(hi_pos - POS_W'(1));
				if (!empty) begin
					sweep_q <= '0;
					stamp_q <= wrap ? STAMP_W'(1) : stamp_q + STAMP_W'(1);
				end
			end else if (state_q == ST_SCAN) begin
				scan_q <= scan_q + ADDR_W'(1);
			end
		end
	end

endmodule

[rtl/range_distinct_count.sv]
// Channel   Direction  Beat contents
// s_axis    in         tuser: func; tdata: write_index, write_value, query_left, query_right
// m_axis    out        tdata: distinct_count
//
// A write beat updates the value store as soon as it is taken.
// A query scans the positions from left to right, one position per cycle through the
// value store read port, then drains the pipeline and hands over the result; an
// empty range skips the scan. Once every 65535 non-empty queries the stamp wraps and
// the seen store is wiped first, all VALUE_COUNT (1024) entries.
// After reset a clearing pass over max(ARRAY_DEPTH, VALUE_COUNT) = 1024 addresses
// zeroes both stores; s_axis_tready stays low until it ends. A stalled result waits
// in the output register while further write beats are still taken.
module range_distinct_count import rdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [10:0] write_index, [20:11] write_value, [31:21] query_left,
	// [42:32] query_right, [47:43] zero
	input  logic [47:0] s_axis_tdata,
	// [0] func
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [10:0] distinct_count, [15:11] zero
	output logic [15:0] m_axis_tdata
);

	localparam int OUT_TDATA_W = 16;

	logic                  in_accept;
	logic [POS_W-1:0]      write_index;
	logic [VALUE_IN_W-1:0] write_value;
	logic [POS_W-1:0]      query_left;
	logic [POS_W-1:0]      query_right;
	logic                  busy;
	logic                  out_free;
	logic                  load_out;
	logic [CNT_W-1:0]      count;
	rdc_ctl_t              ctl;
	logic                  out_valid_q;
	logic [CNT_W-1:0]      out_count_q;

	// Unpack the input beat, first field in the lowest bits.
	assign write_index = s_axis_tdata[POS_W-1:0];
	assign write_value = s_axis_tdata[POS_W+VALUE_IN_W-1:POS_W];
	assign query_left  = s_axis_tdata[2*POS_W+VALUE_IN_W-1:POS_W+VALUE_IN_W];
	assign query_right = s_axis_tdata[3*POS_W+VALUE_IN_W-1:2*POS_W+VALUE_IN_W];

	assign in_accept = s_axis_tvalid && s_axis_tready;

	// The output register may be reloaded in the cycle its beat is taken.
	assign out_free = !out_valid_q || m_axis_tready;

	rdc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_accept   (in_accept),
		.func        (s_axis_tuser),
		.write_index (write_index),
		.write_value (write_value),
		.query_left  (query_left),
		.query_right (query_right),
		.busy        (busy),
		.out_free    (out_free),
		.ready       (s_axis_tready),
		.load_out    (load_out),
		.ctl         (ctl)
	);

	rdc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.busy   (busy),
		.count  (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_count_q <= count;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_count_q);

endmodule
